// File: src/cpt_pkg.sv
`default_nettype none

package cpt_pkg;

  localparam int COORD_BITS       = 16;
  localparam int CPT_MAX_VERTICES = 16;
  localparam int VCNT_W           = 5;
  localparam int DIFF_W           = COORD_BITS + 1;
  localparam int PROD_W           = 2 * DIFF_W;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEST   = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]                    op;
    logic signed [COORD_BITS-1:0]  x_coord;
    logic signed [COORD_BITS-1:0]  y_coord;
  } in_item_t;

  typedef struct packed {
    logic              inside_res;
    logic              refused;
    logic [VCNT_W-1:0] vertex_count;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  // tag that travels with one edge through the cross product pipe
  typedef struct packed {
    logic vld;
    logic last;
  } edge_tag_t;

  typedef struct packed {
    logic vld;
    logic last;
    logic neg;
  } edge_res_t;

endpackage

`default_nettype wire

// File: src/convex_polygon_point_test_top.sv
// channel | ports                        | payload
// input   | in_valid, in_ready, in_data  | in_item_t: op, x_coord, y_coord
// result  | out_valid, out_ready, out_data | out_item_t: inside_res, refused, vertex_count
//
// clear, append, unused ops and a test of an empty store: straight to the finish state,
//   which loads the result register once the output register is free
// test of n vertices: one vertex read per cycle from the vertex ram,
//   then the closing edge, a two-stage cross product pipe and the result register
// in_ready is high only when no item is in work; a result waiting in the output
//   register does not block the next transfer, only the next result
// rst_n is synchronous; vertex ram contents are not cleared, the count is
`default_nettype none

module convex_polygon_point_test_top
  import cpt_pkg::*;
#(
  parameter int MAX_VERTICES = CPT_MAX_VERTICES
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int EW = (CW > VCNT_W) ? CW : VCNT_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_idx_r, rd_cur;
  logic          rd_vld_r, rd_first_r, rd_last_r, clos_r;
  logic          neg_any_r;
  logic          res_inside_r, res_refused_r;
  point_t        first_r, prev_r, pt_r;
  logic          out_valid_r;
  out_item_t     out_data_r;
  logic [EW-1:0] cnt_wide;

  logic          accept, full, out_free;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  point_t        wr_pt, rd_pt;
  edge_tag_t     e_tag;
  edge_res_t     e_res;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign full     = (count_r >= CW'(MAX_VERTICES));
  assign out_free = !out_valid_r || out_ready;
  assign rd_cur   = (state_r == S_IDLE) ? '0 : rd_idx_r;
  assign wr_pt    = '{x: in_data.x_coord, y: in_data.y_coord};

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_re    = 1'b0;
    ram_raddr = rd_idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_FIN;
          case (in_data.op)
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_APPEND: begin
              if (!full) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_TEST: begin
              if (count_r != '0) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_nxt = S_WALK;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_WALK: begin
        if (rd_idx_r < count_r) begin
          ram_re = 1'b1;
        end
        if (e_res.vld && e_res.last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      rd_first_r  <= 1'b0;
      rd_last_r   <= 1'b0;
      clos_r      <= 1'b0;
      neg_any_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      rd_vld_r   <= ram_re;
      rd_first_r <= (state_r == S_IDLE);
      rd_last_r  <= ((rd_cur + CW'(1)) == count_r);
      clos_r     <= rd_vld_r & rd_last_r;
      if (accept) begin
        rd_idx_r <= CW'(1);
      end else if (ram_re) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
      if (accept) begin
        neg_any_r <= 1'b0;
      end else if (e_res.vld && e_res.neg) begin
        neg_any_r <= 1'b1;
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign cnt_wide = EW'(count_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      pt_r          <= wr_pt;
      res_inside_r  <= (in_data.op == OP_TEST) && (count_r == '0);
      res_refused_r <= (in_data.op == OP_APPEND) && full;
    end else if (state_r == S_WALK && e_res.vld && e_res.last) begin
      res_inside_r  <= !(neg_any_r || e_res.neg);
    end
    if (rd_vld_r) begin
      prev_r <= rd_pt;
      if (rd_first_r) begin
        first_r <= rd_pt;
      end
    end
    if (state_r == S_FIN && out_free) begin
      out_data_r.inside_res   <= res_inside_r;
      out_data_r.refused      <= res_refused_r;
      out_data_r.vertex_count <= cnt_wide[VCNT_W-1:0];
    end
  end

  // edge from previous vertex to the one just read, then the closing edge
  always_comb begin
    e_tag.vld  = clos_r | (rd_vld_r & !rd_first_r);
    e_tag.last = clos_r;
  end

  cpt_ram #(
    .WIDTH($bits(point_t)),
    .DEPTH(MAX_VERTICES),
    .AW   (AW)
  ) u_vram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_pt),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd_pt)
  );

  cpt_edge u_edge (
    .clk  (clk),
    .rst_n(rst_n),
    .tag  (e_tag),
    .a_pt (prev_r),
    .b_pt (clos_r ? first_r : rd_pt),
    .p_pt (pt_r),
    .res  (e_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: src/cpt_ram.sv
`default_nettype none

module cpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: src/cpt_edge.sv
`default_nettype none

module cpt_edge
  import cpt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire edge_tag_t tag,
  input  wire point_t    a_pt,
  input  wire point_t    b_pt,
  input  wire point_t    p_pt,
  output edge_res_t      res
);

  // stage 1: edge and point deltas
  logic                     d_vld_r, d_last_r;
  logic signed [DIFF_W-1:0] ex_r, ey_r, dpx_r, dpy_r;
  // stage 2: the two products
  logic                     m_vld_r, m_last_r;
  logic signed [PROD_W-1:0] m1_r, m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r  <= 1'b0;
      d_last_r <= 1'b0;
      m_vld_r  <= 1'b0;
      m_last_r <= 1'b0;
    end else begin
      d_vld_r  <= tag.vld;
      d_last_r <= tag.last;
      m_vld_r  <= d_vld_r;
      m_last_r <= d_last_r;
    end
  end

  always_ff @(posedge clk) begin
    ex_r  <= $signed({b_pt.x[COORD_BITS-1], b_pt.x}) - $signed({a_pt.x[COORD_BITS-1], a_pt.x});
    ey_r  <= $signed({b_pt.y[COORD_BITS-1], b_pt.y}) - $signed({a_pt.y[COORD_BITS-1], a_pt.y});
    dpx_r <= $signed({p_pt.x[COORD_BITS-1], p_pt.x}) - $signed({b_pt.x[COORD_BITS-1], b_pt.x});
    dpy_r <= $signed({p_pt.y[COORD_BITS-1], p_pt.y}) - $signed({b_pt.y[COORD_BITS-1], b_pt.y});
    m1_r  <= ex_r * dpy_r;
    m2_r  <= ey_r * dpx_r;
  end

  // cross product negative when ex*py < ey*px
  always_comb begin
    res.vld  = m_vld_r;
    res.last = m_last_r;
    res.neg  = (m1_r < m2_r);
  end

endmodule

`default_nettype wire

// File: src/cpt_checker.sv
`default_nettype none

module cpt_checker
  import cpt_pkg::*;
#(
  parameter int MAX_VERTICES = CPT_MAX_VERTICES
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while an item is in work");

  a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.refused |->
      out_data.vertex_count == VCNT_W'(MAX_VERTICES) && !out_data.inside_res)
    else $error("refused append with store not full");

endmodule

bind convex_polygon_point_test_top cpt_checker #(
  .MAX_VERTICES(MAX_VERTICES)
) u_cpt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire
